>>> src/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, register map and fixed-point helpers for the escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // operand pairing for the shared multiplier
   typedef enum logic [1:0] {
      MUL_RE_RE,
      MUL_IM_IM,
      MUL_RE_IM
   } mul_sel_type;

   // sequencer to datapath control group
   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        capture_rr;
      logic        capture_dsq;
      logic        update;
   } dp_ctrl_type;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_LIMIT = 1'b0;

   localparam int  CSR_ADDR_WIDTH  = 3;
   localparam int  CSR_DATA_WIDTH  = 32;
   localparam int  LIMIT_RESET     = 255;
   localparam int  COORD_WIDTH     = 32;
   localparam int  PROD_WIDTH      = 64;
   localparam int  RESULT_WIDTH    = 16;

   // clamp a 64-bit signed value to the signed 32-bit range
   function automatic logic signed [COORD_WIDTH-1:0] sat32(
      input logic signed [PROD_WIDTH-1:0] v
   );
      logic signed [COORD_WIDTH-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/mbe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Holds z and c, runs one shared 32x32 multiplier, checks |z|^2 >= 4.
// ----------------------------------------------------------------------------
module mbe_datapath #(
   parameter int FRAC_BITS = 27
) (
   input  logic                                   clock,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0] req_c_real,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0] req_c_imag,
   input  mbe_pkg::dp_ctrl_type                   ctrl,
   output logic                                   escaped
);

   localparam int TSHIFT = 2 * FRAC_BITS + 2;

   logic signed [mbe_pkg::COORD_WIDTH-1:0] c_re_ff, c_im_ff;
   logic signed [mbe_pkg::COORD_WIDTH-1:0] re_ff, re_in;
   logic signed [mbe_pkg::COORD_WIDTH-1:0] im_ff, im_in;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  rr_ff;
   logic signed [mbe_pkg::PROD_WIDTH-1:0]  dsq_ff, dsq_in;
   logic signed [mbe_pkg::COORD_WIDTH-1:0] mul_a, mul_b;
   logic        [mbe_pkg::PROD_WIDTH-1:0]  mag_sum;

   always_comb begin
      case (ctrl.mul_sel)
         mbe_pkg::MUL_RE_RE: begin
            mul_a = re_ff;
            mul_b = re_ff;
         end
         mbe_pkg::MUL_IM_IM: begin
            mul_a = im_ff;
            mul_b = im_ff;
         end
         default: begin
            mul_a = re_ff;
            mul_b = im_ff;
         end
      endcase
   end

   // sign-extended 32-bit operands, full 64-bit product
   assign prod_in = mbe_pkg::PROD_WIDTH'(mul_a) * mbe_pkg::PROD_WIDTH'(mul_b);

   // both squares are non-negative and at most 2^62, so the sum fits unsigned
   assign mag_sum = $unsigned(rr_ff) + $unsigned(prod_ff);
   assign escaped = |(mag_sum >> TSHIFT);
   assign dsq_in  = rr_ff - prod_ff;

   // arithmetic shift rounds toward minus infinity
   assign re_in = mbe_pkg::sat32((dsq_ff >>> FRAC_BITS)
                                 + mbe_pkg::PROD_WIDTH'(c_re_ff));
   assign im_in = mbe_pkg::sat32((prod_ff >>> (FRAC_BITS - 1))
                                 + mbe_pkg::PROD_WIDTH'(c_im_ff));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.load) begin
         c_re_ff <= req_c_real;
         c_im_ff <= req_c_imag;
         re_ff   <= '0;
         im_ff   <= '0;
      end else if (ctrl.update) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
      if (ctrl.capture_rr) begin
         rr_ff <= prod_ff;
      end
      if (ctrl.capture_dsq) begin
         dsq_ff <= dsq_in;
      end
   end

endmodule

>>> src/mandelbrot_escape_time_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Iterates z = z*z + c from z = 0 and reports the escape iteration count (0 if the limit is reached).
//
//  channel   ports                                    handshake
//  request   req_c_real, req_c_imag                   start && !busy
//  result    rsp_escape_count                         rsp_valid, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,     APB read and write, pready = 1
//            prdata, pready
//
// One multiplier forms re^2, im^2 and re*im in turn; each iteration steps
// through S_SQ_RE, S_SQ_IM, S_CROSS and S_UPDATE. Busy is high, and no new
// request is taken, until S_CROSS sees escape or the limit; the result
// strobes as busy drops. Reset clears the sequencer and sets the limit
// to 255. The result cannot be stalled; it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
   parameter int FRAC_BITS   = 27,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0]    req_c_real,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0]    req_c_imag,
   output logic                                      rsp_valid,
   output logic        [mbe_pkg::RESULT_WIDTH-1:0]   rsp_escape_count,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic        [mbe_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic        [mbe_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic        [mbe_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                      pready
);

   localparam int LW = (COUNT_WIDTH < mbe_pkg::RESULT_WIDTH) ? COUNT_WIDTH
                                                             : mbe_pkg::RESULT_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQ_RE,
      S_SQ_IM,
      S_CROSS,
      S_UPDATE
   } state_type;

   state_type                        state_ff;
   logic                             busy_ff;
   logic                             rsp_valid_ff;
   logic [mbe_pkg::RESULT_WIDTH-1:0] rsp_count_ff;
   logic [LW-1:0]                    count_ff;
   logic [LW-1:0]                    limit_ff;
   logic                             accept;
   logic                             csr_write;
   logic                             at_limit;
   logic                             escaped;
   mbe_pkg::dp_ctrl_type             ctrl;

   assign accept    = start && !busy_ff;
   assign csr_write = psel && penable && pwrite;
   assign at_limit  = (count_ff == limit_ff);

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;
   assign pready           = 1'b1;
   assign prdata = (paddr[2] == mbe_pkg::CSR_IDX_LIMIT)
                 ? mbe_pkg::CSR_DATA_WIDTH'(limit_ff) : '0;

   always_comb begin
      ctrl.load        = accept;
      ctrl.capture_rr  = (state_ff == S_SQ_IM);
      ctrl.capture_dsq = (state_ff == S_CROSS);
      ctrl.update      = (state_ff == S_UPDATE);
      case (state_ff)
         S_SQ_RE: ctrl.mul_sel = mbe_pkg::MUL_RE_RE;
         S_SQ_IM: ctrl.mul_sel = mbe_pkg::MUL_IM_IM;
         default: ctrl.mul_sel = mbe_pkg::MUL_RE_IM;
      endcase
   end

   mbe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .req_c_real (req_c_real),
      .req_c_imag (req_c_imag),
      .ctrl       (ctrl),
      .escaped    (escaped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LW'(mbe_pkg::LIMIT_RESET);
      end else if (csr_write && paddr[2] == mbe_pkg::CSR_IDX_LIMIT) begin
         limit_ff <= pwdata[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SQ_RE;
                  busy_ff  <= 1'b1;
                  count_ff <= '0;
               end
            end
            S_SQ_RE: state_ff <= S_SQ_IM;
            S_SQ_IM: state_ff <= S_CROSS;
            S_CROSS: begin
               // drop out on escape or when the limit is reached
               if (escaped || at_limit) begin
                  state_ff     <= S_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= at_limit ? '0
                                           : mbe_pkg::RESULT_WIDTH'(count_ff);
               end else begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= S_SQ_RE;
               count_ff <= count_ff + 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy_ff)) |-> rsp_valid_ff)
      else $error("busy dropped without a result");

   a_result_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("request accepted but core not busy");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!busy_ff && state_ff == S_IDLE))
      else $error("result strobe while still iterating");

endmodule

>>> test/mandelbrot_escape_time_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core testbench
// This testbench sends complex points to the core through the start/busy
// request handshake. For each accepted request it predicts the escape count
// in fixed point at the block's widths and checks the one-cycle result
// strobe against that prediction. The iteration limit is written and read
// back over the APB port only while no result is outstanding. The run has a
// short directed part first, then random traffic under three sender idle
// rates.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;

   localparam int FRAC_BITS = 27;
   localparam int MAX_GAP   = 40;
   localparam logic [mbe_pkg::CSR_ADDR_WIDTH-1:0] LIMIT_ADDR = {mbe_pkg::CSR_IDX_LIMIT, 2'b00};

   // fixed-point constants, 27 fraction bits
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_ZERO     = 32'sd0;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_ONE      = 32'sd134217728;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_TWO      = 32'sd268435456;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_MAX      = 32'sh7fffffff;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_MIN      = 32'sh80000000;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_QUARTER  = 32'sd33554432;
   localparam logic signed [mbe_pkg::COORD_WIDTH-1:0] FX_CUSP_OUT = 32'sd34896609;

   typedef struct {
      logic signed [mbe_pkg::COORD_WIDTH-1:0] c_real;
      logic signed [mbe_pkg::COORD_WIDTH-1:0] c_imag;
      logic        [mbe_pkg::RESULT_WIDTH-1:0] escape_count;
   } escape_entry_type;

   logic                                      clock;
   logic                                      reset      = 1'b1;
   logic                                      start      = 1'b0;
   logic                                      busy;
   logic signed [mbe_pkg::COORD_WIDTH-1:0]    req_c_real = '0;
   logic signed [mbe_pkg::COORD_WIDTH-1:0]    req_c_imag = '0;
   logic                                      rsp_valid;
   logic        [mbe_pkg::RESULT_WIDTH-1:0]   rsp_escape_count;
   logic                                      psel       = 1'b0;
   logic                                      penable    = 1'b0;
   logic                                      pwrite     = 1'b0;
   logic        [mbe_pkg::CSR_ADDR_WIDTH-1:0] paddr      = '0;
   logic        [mbe_pkg::CSR_DATA_WIDTH-1:0] pwdata     = '0;
   logic        [mbe_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                      pready;

   escape_entry_type                 pending_escapes[$];
   logic [mbe_pkg::RESULT_WIDTH-1:0] iter_limit = mbe_pkg::RESULT_WIDTH'(mbe_pkg::LIMIT_RESET);
   int                               idle_pct     = 0;
   int                               errors       = 0;
   int                               checked      = 0;
   int                               limit_writes = 0;
   longint                           cycle_count  = 0;
   longint                           cycle_budget = 0;

   mandelbrot_escape_time_core #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_WIDTH(mbe_pkg::RESULT_WIDTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_c_real      (req_c_real),
      .req_c_imag      (req_c_imag),
      .rsp_valid       (rsp_valid),
      .rsp_escape_count(rsp_escape_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [mbe_pkg::COORD_WIDTH-1:0] clamp_coord(input longint v);
      logic signed [mbe_pkg::COORD_WIDTH-1:0] r;
      if (v > 64'sd2147483647) begin
         r = FX_MAX;
      end else if (v < -64'sd2147483648) begin
         r = FX_MIN;
      end else begin
         r = v[mbe_pkg::COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic [mbe_pkg::RESULT_WIDTH-1:0] escape_iterations(
      input logic signed [mbe_pkg::COORD_WIDTH-1:0] cr,
      input logic signed [mbe_pkg::COORD_WIDTH-1:0] ci,
      input logic        [mbe_pkg::RESULT_WIDTH-1:0] lim
   );
      longint      zr, zi, rr, ii, ri;
      logic [63:0] mag;
      int          n;
      bit          gone;
      zr = 0;
      zi = 0;
      n = 0;
      gone = 1'b0;
      while (!gone && n < lim) begin
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         mag = rr + ii;
         // |z| >= 2 in squared form; the threshold only exists below 64 bits
         if (2 * FRAC_BITS + 2 <= 63 && mag >= (64'd1 << (2 * FRAC_BITS + 2))) begin
            gone = 1'b1;
         end else begin
            zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + longint'(cr));
            zi = clamp_coord((ri >>> (FRAC_BITS - 1)) + longint'(ci));
            n++;
         end
      end
      if (n == lim) n = 0;
      return mbe_pkg::RESULT_WIDTH'(n);
   endfunction

   // watchdog: budget grows with the slowest legal cost of each request
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > 4 * cycle_budget + 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      escape_entry_type head;
      if (!reset && rsp_valid) begin
         if (pending_escapes.size() == 0) begin
            $error("escape_count: no request outstanding, actual %0d", rsp_escape_count);
            errors++;
         end else begin
            head = pending_escapes.pop_front();
            checked++;
            if (rsp_escape_count !== head.escape_count) begin
               $error("escape_count for c=(%0d,%0d): expected %0d, actual %0d",
                      head.c_real, head.c_imag, head.escape_count, rsp_escape_count);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(input logic [mbe_pkg::CSR_DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      iter_limit = value[mbe_pkg::RESULT_WIDTH-1:0];
      limit_writes++;
      cycle_budget += 16;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LIMIT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[mbe_pkg::RESULT_WIDTH-1:0] !== iter_limit) begin
         $error("iteration_limit readback: expected %0d, actual %0d",
                iter_limit, prdata[mbe_pkg::RESULT_WIDTH-1:0]);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      cycle_budget += 16;
      @(posedge clock);
   endtask

   task automatic send_point(input logic signed [mbe_pkg::COORD_WIDTH-1:0] cr,
                             input logic signed [mbe_pkg::COORD_WIDTH-1:0] ci);
      int               gap;
      escape_entry_type item;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_c_real <= cr;
      req_c_imag <= ci;
      do @(posedge clock); while (busy);
      item.c_real       = cr;
      item.c_imag       = ci;
      item.escape_count = escape_iterations(cr, ci, iter_limit);
      pending_escapes.insert(pending_escapes.size(), item);
      cycle_budget += 4 * longint'(iter_limit) + 8 + MAX_GAP;
   endtask

   // drop start and hold off until every request has answered
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_escapes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      cycle_budget += 8;
   endtask

   task automatic draw_point(output logic signed [mbe_pkg::COORD_WIDTH-1:0] cr,
                             output logic signed [mbe_pkg::COORD_WIDTH-1:0] ci);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         // region around the set: re in [-2.25, 0.75], im in [-1.25, 1.25]
         cr = 32'($urandom_range(0, 402653184)) - 32'd301989888;
         ci = 32'($urandom_range(0, 335544320)) - 32'd167772160;
      end else if (pick < 17) begin
         cr = $urandom;
         ci = $urandom;
      end else begin
         cr = 32'($urandom_range(0, 134217728)) - 32'd67108864;
         ci = 32'($urandom_range(0, 134217728)) - 32'd67108864;
      end
   endtask

   task automatic test_reset_state();
      idle_pct = 0;
      csr_read_check();
      send_point(FX_ZERO, FX_ZERO);
      send_point(-FX_TWO, FX_ZERO);
      wait_for_results();
   endtask

   task automatic test_directed_points();
      idle_pct = 0;
      send_point(FX_MAX, FX_MAX);
      send_point(FX_MIN, FX_MIN);
      send_point(FX_MAX, FX_MIN);
      send_point(FX_MIN, FX_MAX);
      send_point(FX_ZERO, FX_MIN);
      send_point(FX_MIN, FX_ZERO);
      send_point(FX_QUARTER, FX_ZERO);
      send_point(-32'sd100663296, 32'sd13421773);
      send_point(FX_ZERO, FX_ONE);
      send_point(-FX_ONE, FX_ZERO);
      send_point(FX_ZERO, FX_TWO);
      send_point(FX_TWO, FX_ZERO);
      send_point(-FX_TWO + 32'sd1, FX_ZERO);
      send_point(32'sd40265318, 32'sd67108864);
      wait_for_results();
   endtask

   task automatic test_limit_extremes();
      idle_pct = 0;
      // zero limit runs no iteration
      csr_write(32'd0);
      csr_read_check();
      send_point(FX_ZERO, FX_ZERO);
      send_point(-32'sd67108864, FX_ZERO);
      wait_for_results();
      csr_write(32'd1);
      send_point(FX_ZERO, FX_ZERO);
      send_point(FX_TWO, FX_ZERO);
      wait_for_results();
      // largest limit: only points that leave quickly
      csr_write(32'd65535);
      csr_read_check();
      send_point(FX_MAX, FX_ZERO);
      send_point(FX_CUSP_OUT, FX_ZERO);
      send_point(FX_MIN, 32'sd12345);
      wait_for_results();
      // upper data bits fall outside the register
      csr_write(32'hffff_0003);
      csr_read_check();
      send_point(FX_CUSP_OUT, FX_ZERO);
      send_point(32'sd40265318, 32'sd67108864);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int pct, input int phases, input int per_phase);
      logic [mbe_pkg::RESULT_WIDTH-1:0]       lim;
      logic signed [mbe_pkg::COORD_WIDTH-1:0] cr, ci;
      int                                     p, k;
      for (p = 0; p < phases; p++) begin
         wait_for_results();
         case ($urandom_range(0, 5))
            0:       lim = 16'd1;
            1:       lim = 16'd2;
            5:       lim = 16'd255;
            default: lim = 16'($urandom_range(3, 48));
         endcase
         csr_write({16'($urandom), lim});
         csr_read_check();
         idle_pct = pct;
         for (k = 0; k < per_phase; k++) begin
            draw_point(cr, ci);
            send_point(cr, ci);
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_points();
      test_limit_extremes();
      test_random_traffic(17, 6, 86);
      test_random_traffic(73, 6, 86);
      test_random_traffic(0, 6, 86);
      wait_for_results();
      repeat (16) @(posedge clock);
      $display("summary: %0d results checked, %0d limit writes, %0d errors", checked,
               limit_writes, errors);
      $display("summary: limits 0, 1, 65535 and random, sender idle 17, 73 and 0 percent");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
src/mbe_pkg.sv
src/mbe_datapath.sv
src/mandelbrot_escape_time_core.sv
test/mandelbrot_escape_time_core_tb.sv
